### design/edf_pkg.sv
package edf_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RESTART = 2'd2
   } command_type;

   localparam int TIME_W  = 32;
   localparam int FIELD_W = 16;
   localparam int COUNT_W = 5;
   localparam int SLOT_W  = 4;

   // Per-cell strobes driven by the sequencer.
   typedef struct packed {
      logic load;
      logic restart;
      logic dec;
   } cell_ctrl_type;

   // Running best candidate that walks down the chain.
   typedef struct packed {
      logic              valid;
      logic              found;
      logic [TIME_W-1:0] deadline;
   } token_type;

endpackage

### design/edf_cell.sv
module edf_cell
   import edf_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic               active,
   input  logic [IDX_W-1:0]   cell_id,
   input  logic [TIME_W-1:0]  now,
   input  logic [FIELD_W-1:0] ld_exec,
   input  logic [FIELD_W-1:0] ld_period,
   input  logic [FIELD_W-1:0] ld_deadline,
   input  token_type          tok_in,
   input  logic [IDX_W-1:0]   chosen_in,
   output token_type          tok_out,
   output logic [IDX_W-1:0]   chosen_out
);

   logic [FIELD_W-1:0] exec_ff;
   logic [FIELD_W-1:0] period_ff;
   logic [FIELD_W-1:0] dl_ff;
   logic [TIME_W-1:0]  sum_ff;
   logic [FIELD_W-1:0] rem_ff;
   logic [TIME_W-1:0]  nr_ff;
   logic [TIME_W-1:0]  ad_ff;
   token_type          tok_ff;
   logic [IDX_W-1:0]   chosen_ff;

   logic               release_now;
   logic [FIELD_W-1:0] rem_in;
   logic [TIME_W-1:0]  ad_in;
   logic [TIME_W-1:0]  diff;
   logic               take;
   token_type          tok_in_next;
   logic [IDX_W-1:0]   chosen_in_next;

   always_comb begin
      release_now = tok_in.valid && active && (nr_ff == now);
      rem_in      = release_now ? exec_ff : rem_ff;
      ad_in       = release_now ? sum_ff : ad_ff;
      // serial-number order: earlier when the difference has its top bit set
      diff        = ad_in - tok_in.deadline;
      take        = tok_in.valid && active && (rem_in != '0)
                    && (!tok_in.found || diff[TIME_W-1]);
      tok_in_next = tok_in;
      chosen_in_next = chosen_in;
      if (take) begin
         tok_in_next.found    = 1'b1;
         tok_in_next.deadline = ad_in;
         chosen_in_next       = cell_id;
      end
   end

   // Task tables: undefined until loaded.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         exec_ff   <= ld_exec;
         period_ff <= ld_period;
         dl_ff     <= ld_deadline;
      end
      // now is stable while a tick walks the chain
      sum_ff    <= now + {{(TIME_W-FIELD_W){1'b0}}, dl_ff};
      chosen_ff <= chosen_in_next;
   end

   always_ff @(posedge clock) begin
      tok_ff.found    <= tok_in_next.found;
      tok_ff.deadline <= tok_in_next.deadline;
      if (reset) begin
         rem_ff       <= '0;
         nr_ff        <= '0;
         ad_ff        <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
         if (ctrl.restart || ctrl.load) begin
            rem_ff <= '0;
            nr_ff  <= '0;
            ad_ff  <= '0;
         end else if (release_now) begin
            rem_ff <= exec_ff;
            ad_ff  <= sum_ff;
            nr_ff  <= nr_ff + {{(TIME_W-FIELD_W){1'b0}}, period_ff};
         end else if (ctrl.dec) begin
            rem_ff <= rem_ff - FIELD_W'(1);
         end
      end
   end

   assign tok_out    = tok_ff;
   assign chosen_out = chosen_ff;

endmodule

### design/edf_task_scheduler.sv
// Earliest-deadline-first scheduler for up to MAX_TASKS periodic tasks, one
// cell per task slot in a chain. Load, restart and unknown commands are done in
// the cycle in which they are accepted. A tick is accepted, then the
// best-candidate beat walks down the chain, registered in each cell (each cell
// releases its task and compares deadlines as the beat passes), the beat leaving
// the last cell is captured, and then the result is posted and the chosen task
// charged, held back while the previous result is still untaken.
module edf_task_scheduler
   import edf_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [SLOT_W-1:0]  req_task_index,
   input  logic [FIELD_W-1:0] req_exec_time,
   input  logic [FIELD_W-1:0] req_period,
   input  logic [FIELD_W-1:0] req_rel_deadline,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_idle,
   output logic [SLOT_W-1:0]  rsp_selected_task,
   output logic [TIME_W-1:0]  rsp_tick_time,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_TASKS);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  num_tasks_ff;
   logic [TIME_W-1:0]   time_ff;
   logic                tok0_valid_ff;
   logic                best_found_ff;
   logic [IDX_W-1:0]    best_chosen_ff;
   logic                rsp_valid_ff;
   logic                rsp_idle_ff;
   logic [SLOT_W-1:0]   rsp_sel_ff;
   logic [TIME_W-1:0]   rsp_time_ff;

   logic                accept;
   logic                is_load;
   logic                is_tick;
   logic                is_restart;
   logic                rsp_free;
   logic                finish;
   logic [IDX_W+SLOT_W-1:0] chosen_ext;

   cell_ctrl_type       cell_ctrl [MAX_TASKS];
   token_type           tok       [MAX_TASKS+1];
   logic [IDX_W-1:0]    chos      [MAX_TASKS+1];

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign is_load    = accept && (req_command == CMD_LOAD);
   assign is_tick    = accept && (req_command == CMD_TICK);
   assign is_restart = accept && (req_command == CMD_RESTART);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == S_WAIT) && rsp_free;
   assign chosen_ext = {{SLOT_W{1'b0}}, best_chosen_ff};

   assign tok[0] = '{valid: tok0_valid_ff, found: 1'b0, deadline: '0};
   assign chos[0] = '0;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      assign cell_ctrl[i].load    = is_load && (int'(req_task_index) == i);
      assign cell_ctrl[i].restart = is_restart;
      assign cell_ctrl[i].dec     = finish && best_found_ff
                                    && (best_chosen_ff == IDX_W'(i));

      edf_cell #(
         .IDX_W (IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .active      (int'(num_tasks_ff) > i),
         .cell_id     (IDX_W'(i)),
         .now         (time_ff),
         .ld_exec     (req_exec_time),
         .ld_period   (req_period),
         .ld_deadline (req_rel_deadline),
         .tok_in      (tok[i]),
         .chosen_in   (chos[i]),
         .tok_out     (tok[i+1]),
         .chosen_out  (chos[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (is_tick) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[MAX_TASKS].valid) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         num_tasks_ff  <= COUNT_W'(1);
         time_ff       <= '0;
         tok0_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tok0_valid_ff <= is_tick;
         if (csr_wr_en) begin
            num_tasks_ff <= csr_wr_data;
         end
         if (is_restart) begin
            time_ff <= '0;
         end else if (finish) begin
            time_ff <= time_ff + TIME_W'(1);
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      // capture the beat leaving the last cell
      if (state_ff == S_SCAN && tok[MAX_TASKS].valid) begin
         best_found_ff  <= tok[MAX_TASKS].found;
         best_chosen_ff <= chos[MAX_TASKS];
      end
      if (finish) begin
         rsp_idle_ff <= !best_found_ff;
         rsp_sel_ff  <= best_found_ff ? chosen_ext[SLOT_W-1:0] : '0;
         rsp_time_ff <= time_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_idle          = rsp_idle_ff;
   assign rsp_selected_task = rsp_sel_ff;
   assign rsp_tick_time     = rsp_time_ff;

`ifndef ASSERT_OFF
   a_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_TASKS].valid |-> state_ff == S_SCAN)
      else $error("beat left the chain outside a scan");

   a_tick_injects: assert property (@(posedge clock) disable iff (reset)
      is_tick |=> tok0_valid_ff)
      else $error("tick did not inject a beat");

   a_chosen_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && best_found_ff) |->
         (int'(best_chosen_ff) < int'(num_tasks_ff)))
      else $error("chosen slot is not active");

   a_time_advance: assert property (@(posedge clock) disable iff (reset)
      finish |=> time_ff == $past(time_ff) + TIME_W'(1))
      else $error("time did not advance after a tick");
`endif

endmodule
